[src/uvsig_pkg.sv]
`default_nettype none

package uvsig_pkg;

  // Sequence phase codes
  localparam logic [1:0] PhTop    = 2'd0;
  localparam logic [1:0] PhInner  = 2'd1;
  localparam logic [1:0] PhBottom = 2'd2;

  // Configuration register indexes
  localparam logic [7:0] CfgSliceCount = 8'd0;
  localparam logic [7:0] CfgStackCount = 8'd1;

  // Reset values of the configuration registers
  localparam logic [7:0] SliceCountRst = 8'd20;
  localparam logic [7:0] StackCountRst = 8'd20;

  // Effective mesh dimensions after clamping
  typedef struct packed {
    logic [7:0] slices;
    logic [7:0] stacks;
  } dims_t;

  // One emitted triangle
  typedef struct packed {
    logic [15:0] first_index;
    logic [15:0] second_index;
    logic [15:0] third_index;
    logic        last_of_mesh;
  } tri_t;

endpackage

`default_nettype wire

[src/uvsig_cfg.sv]
`default_nettype none

module uvsig_cfg import uvsig_pkg::*; #(
  parameter int MAX_SLICES = 255,
  parameter int MAX_STACKS = 255
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  input  wire logic [7:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  output dims_t           dims_o
);

  // Upper clamps, limited to what an 8-bit register can hold
  localparam logic [7:0] SliceCap = 8'((MAX_SLICES > 255) ? 255 : MAX_SLICES);
  localparam logic [7:0] StackCap = 8'((MAX_STACKS > 255) ? 255 : MAX_STACKS);

  logic [7:0] slice_count_q, slice_count_d;
  logic [7:0] stack_count_q, stack_count_d;

  // Register write decode
  always_comb begin
    slice_count_d = slice_count_q;
    stack_count_d = stack_count_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSliceCount: slice_count_d = cfg_data_i;
        CfgStackCount: stack_count_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_count_q <= SliceCountRst;
      stack_count_q <= StackCountRst;
    end else begin
      slice_count_q <= slice_count_d;
      stack_count_q <= stack_count_d;
    end
  end

  // Clamp to the legal range
  always_comb begin
    dims_o.slices = slice_count_q;
    if (slice_count_q < 8'd3) dims_o.slices = 8'd3;
    else if (slice_count_q > SliceCap) dims_o.slices = SliceCap;
    dims_o.stacks = stack_count_q;
    if (stack_count_q < 8'd2) dims_o.stacks = 8'd2;
    else if (stack_count_q > StackCap) dims_o.stacks = StackCap;
  end

endmodule

`default_nettype wire

[src/uvsig_seq.sv]
`default_nettype none

module uvsig_seq import uvsig_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  accept_i,
  input  wire logic  restart_i,
  input  wire dims_t dims_i,
  output tri_t       tri_o
);

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  ring_q, ring_d;
  logic [7:0]  slice_q, slice_d;
  logic        half_q, half_d;
  logic [15:0] base_q, base_d;

  // State seen by this word, after an optional restart
  logic [1:0]  phase_c;
  logic [7:0]  ring_c;
  logic [7:0]  slice_c;
  logic        half_c;
  logic [15:0] base_c;

  logic [15:0] ring_verts;
  logic [7:0]  slice_inc;
  logic        slice_end;
  logic [7:0]  ring_inc;
  logic [15:0] idx_a;
  logic [15:0] idx_b;
  logic [16:0] pole_prod;
  logic [15:0] pole;
  logic [15:0] bot_base;

  always_comb begin
    phase_c = restart_i ? PhTop : phase_q;
    ring_c  = restart_i ? 8'd0  : ring_q;
    slice_c = restart_i ? 8'd0  : slice_q;
    half_c  = restart_i ? 1'b0  : half_q;
    base_c  = restart_i ? 16'd1 : base_q;
  end

  // Shared arithmetic
  assign ring_verts = {8'd0, dims_i.slices} + 16'd1;
  assign slice_inc  = slice_c + 8'd1;
  assign slice_end  = slice_inc >= dims_i.slices;
  assign ring_inc   = ring_c + 8'd1;
  assign idx_a      = base_c + {8'd0, slice_c};
  assign idx_b      = idx_a + ring_verts;
  // bottom pole: (T-1)(S+1)+1
  assign pole_prod  = {9'd0, dims_i.stacks - 8'd1} * {8'd0, ring_verts[8:0]};
  assign pole       = pole_prod[15:0] + 16'd1;
  assign bot_base   = pole - ring_verts;

  // Triangle selection and next state
  always_comb begin
    phase_d = phase_c;
    ring_d  = ring_c;
    slice_d = slice_c;
    half_d  = half_c;
    base_d  = base_c;
    tri_o.last_of_mesh = 1'b0;
    unique case (phase_c)
      PhInner: begin
        if (!half_c) begin
          tri_o.first_index  = idx_a;
          tri_o.second_index = idx_a + 16'd1;
          tri_o.third_index  = idx_b;
          half_d = 1'b1;
        end else begin
          tri_o.first_index  = idx_b;
          tri_o.second_index = idx_a + 16'd1;
          tri_o.third_index  = idx_b + 16'd1;
          half_d  = 1'b0;
          slice_d = slice_inc;
          if (slice_end) begin
            slice_d = 8'd0;
            ring_d  = ring_inc;
            base_d  = base_c + ring_verts;
            if (ring_inc >= dims_i.stacks - 8'd2) phase_d = PhBottom;
          end
        end
      end
      PhBottom: begin
        tri_o.first_index  = pole;
        tri_o.second_index = bot_base + {8'd0, slice_c};
        tri_o.third_index  = bot_base + {8'd0, slice_c} + 16'd1;
        slice_d = slice_inc;
        if (slice_end) begin
          tri_o.last_of_mesh = 1'b1;
          phase_d = PhTop;
          ring_d  = 8'd0;
          slice_d = 8'd0;
          half_d  = 1'b0;
          base_d  = 16'd1;
        end
      end
      default: begin
        // top cap fan round the north pole
        tri_o.first_index  = 16'd0;
        tri_o.second_index = {8'd0, slice_c} + 16'd2;
        tri_o.third_index  = {8'd0, slice_c} + 16'd1;
        slice_d = slice_inc;
        if (slice_end) begin
          slice_d = 8'd0;
          half_d  = 1'b0;
          ring_d  = 8'd0;
          base_d  = 16'd1;
          phase_d = (dims_i.stacks > 8'd2) ? PhInner : PhBottom;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhTop;
      ring_q  <= 8'd0;
      slice_q <= 8'd0;
      half_q  <= 1'b0;
      base_q  <= 16'd1;
    end else if (accept_i) begin
      phase_q <= phase_d;
      ring_q  <= ring_d;
      slice_q <= slice_d;
      half_q  <= half_d;
      base_q  <= base_d;
    end
  end

endmodule

`default_nettype wire

[src/uv_sphere_index_generator_core.sv]
// A triangle word is registered and appears on the output in the cycle after its request is accepted.
// Throughput: one request per cycle; the output register frees as it is read, so
// requests keep flowing while out_ready_i stays high.
// Reset (rst_ni low, asynchronous): counts return to 20 slices and 20 stacks, the
// sequence returns to the first top-cap triangle and the output register empties.
`default_nettype none

module uv_sphere_index_generator_core import uvsig_pkg::*; #(
  parameter int MAX_SLICES = 255,
  parameter int MAX_STACKS = 255
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        restart_i,
  // triangle channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      first_index_o,
  output logic [15:0]      second_index_o,
  output logic [15:0]      third_index_o,
  output logic             last_of_mesh_o
);

  dims_t dims;
  tri_t  tri_c;
  tri_t  out_q;
  logic  out_valid_q;
  logic  accept;

  assign cfg_ready_o = 1'b1;

  uvsig_cfg #(
    .MAX_SLICES (MAX_SLICES),
    .MAX_STACKS (MAX_STACKS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .dims_o      (dims)
  );

  // Accept whenever the output register is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  uvsig_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .restart_i (restart_i),
    .dims_i    (dims),
    .tri_o     (tri_c)
  );

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= tri_c;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign first_index_o  = out_q.first_index;
  assign second_index_o = out_q.second_index;
  assign third_index_o  = out_q.third_index;
  assign last_of_mesh_o = out_q.last_of_mesh;

endmodule

`default_nettype wire

[src/uvsig_chk.sv]
`default_nettype none

module uvsig_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        restart_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] first_index_o,
  input wire logic [15:0] second_index_o,
  input wire logic [15:0] third_index_o,
  input wire logic        last_of_mesh_o
);

  // A stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(first_index_o)
      && $stable(second_index_o) && $stable(third_index_o) && $stable(last_of_mesh_o))
    else $error("stalled triangle word changed");

  // Every accepted request yields a word in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request produced no word");

  // Requests are only held off by a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request stalled without output back-pressure");

  // A restart always opens with a top-cap triangle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && restart_i |=> first_index_o == 16'd0 && !last_of_mesh_o)
    else $error("restart did not begin at the top cap");

  // The closing triangle sits on the bottom pole, never vertex zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_mesh_o |-> first_index_o != 16'd0)
    else $error("last triangle not on the bottom pole");

endmodule

bind uv_sphere_index_generator_core uvsig_chk u_uvsig_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .restart_i      (restart_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .first_index_o  (first_index_o),
  .second_index_o (second_index_o),
  .third_index_o  (third_index_o),
  .last_of_mesh_o (last_of_mesh_o)
);

`default_nettype wire
